// ===== hw/rtl/ethernet_ip_header_parser_defines.svh =====
// Assertion macros for the Ethernet/IP header parser.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ETHERNET_IP_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_IP_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EIPH_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EIPH_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/eiph_pkg.sv =====
// Shared types, codes and helpers for the Ethernet/IP header parser.
// No dependencies; used by eiph_frame_track, eiph_summary and the top level.
`default_nettype none

package eiph_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

	// ethertypes and IP protocol numbers
	localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_PROTO_ICMP = 8'd1;
	localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
	localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

	// frame byte offsets
	localparam int unsigned OFS_TYPE_HI = 12;
	localparam int unsigned OFS_TYPE_LO = 13;
	localparam int unsigned OFS_IP      = 14;
	localparam int unsigned OFS_ARP_OP_HI = 20;
	localparam int unsigned OFS_ARP_OP_LO = 21;

	// offsets inside the IPv4 header
	localparam int unsigned IP_OFS_TOTLEN_HI = 2;
	localparam int unsigned IP_OFS_TOTLEN_LO = 3;
	localparam int unsigned IP_OFS_TTL   = 8;
	localparam int unsigned IP_OFS_PROTO = 9;
	localparam int unsigned IP_OFS_ADDR  = 12;
	localparam int unsigned IP_OFS_ADDR_END = 20;

	// offsets inside the layer-4 header
	localparam int unsigned L4_OFS_PORTS_END = 4;
	localparam int unsigned L4_OFS_TCP_FLAGS = 13;

	// result codes
	localparam logic [1:0] FK_OTHER = 2'd0;
	localparam logic [1:0] FK_ARP   = 2'd1;
	localparam logic [1:0] FK_IPV4  = 2'd2;

	localparam logic [2:0] L4_NONE    = 3'd0;
	localparam logic [2:0] L4_TCP     = 3'd1;
	localparam logic [2:0] L4_UDP     = 3'd2;
	localparam logic [2:0] L4_ICMP    = 3'd3;
	localparam logic [2:0] L4_UNKNOWN = 3'd4;

	localparam logic [1:0] ARP_K_OTHER   = 2'd0;
	localparam logic [1:0] ARP_K_REQUEST = 2'd1;
	localparam logic [1:0] ARP_K_REPLY   = 2'd2;

	localparam logic [15:0] OC_ZERO_NEG = 16'hffff;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic [2:0]  l4_kind;
		logic [5:0]  ip_header_len;
		logic        ip_checksum_ok;
		logic        tcp_checksum_ok;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  tcp_flag_bits;
		logic [1:0]  arp_kind;
		logic [7:0]  icmp_kind;
		logic [7:0]  time_to_live;
	} result_t;

	// frame state captured at the last byte
	typedef struct packed {
		logic [15:0] frame_type;
		logic [5:0]  hdr_len;
		logic [15:0] total_len;
		logic [7:0]  protocol;
		logic [15:0] hdr_sum;
		logic [15:0] seg_sum;
		logic [15:0] addr_sum;
		logic [31:0] ports;
		logic [7:0]  ttl;
		logic [7:0]  tcp_flags;
		logic [15:0] arp_op;
		logic [7:0]  icmp_type;
	} snap_t;

	// ones'-complement 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// byte placed in its 16-bit word by position parity
	function automatic logic [15:0] byte_word(input logic [7:0] b, input logic odd);
		return odd ? {8'h00, b} : {b, 8'h00};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/eiph_stream_if.sv =====
// Valid/ready stream channel for the Ethernet/IP header parser.
// Payload type is set where the channel is instantiated.
`default_nettype none

interface eiph_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/eiph_frame_track.sv =====
// Per-byte frame state: ethertype, IPv4 header fields, running checksums.
// Uses eiph_pkg and eiph_stream_if; hands a snapshot on each last byte.
`default_nettype none

module eiph_frame_track #(
	parameter int unsigned MAX_FRAME_BYTES = eiph_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	eiph_stream_if.sink     frame,
	output eiph_pkg::snap_t snap_s1,
	output logic            snap_valid_s1,
	input  wire             snap_ready
);
	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_BYTES);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [15:0] ftw_q, ftw_n;
	logic [5:0]  hl_q, hl_n;
	logic [15:0] tl_q, tl_n;
	logic [7:0]  proto_q, proto_n;
	logic [15:0] hsum_q, hsum_n;
	logic [15:0] ssum_q, ssum_n;
	logic [15:0] asum_q, asum_n;
	logic [31:0] ports_q, ports_n;
	logic [7:0]  ttl_q, ttl_n;
	logic [7:0]  flags_q, flags_n;
	logic [15:0] arp_op_q, arp_op_n;
	logic [7:0]  icmp_q, icmp_n;

	logic [POS_W-1:0] ip_idx;
	logic [POS_W-1:0] l4_idx;
	logic [15:0] seg_len;
	logic [15:0] bword;
	logic [7:0]  b;
	logic        accept;

	assign b = frame.data.data_byte;
	assign frame.ready = !snap_valid_s1 || snap_ready;
	assign accept = frame.valid && frame.ready;

	always_comb begin
		pos_n    = pos_q;
		ftw_n    = ftw_q;
		hl_n     = hl_q;
		tl_n     = tl_q;
		proto_n  = proto_q;
		hsum_n   = hsum_q;
		ssum_n   = ssum_q;
		asum_n   = asum_q;
		ports_n  = ports_q;
		ttl_n    = ttl_q;
		flags_n  = flags_q;
		arp_op_n = arp_op_q;
		icmp_n   = icmp_q;

		// word parity of the IP and L4 offsets equals pos parity (header len is 4-aligned)
		bword   = eiph_pkg::byte_word(b, pos_q[0]);
		ip_idx  = pos_q - POS_W'(eiph_pkg::OFS_IP);
		l4_idx  = '0;
		seg_len = '0;

		if (pos_q < POS_LIMIT) begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q == POS_W'(eiph_pkg::OFS_TYPE_HI)) begin
				ftw_n[15:8] = b;
			end else if (pos_q == POS_W'(eiph_pkg::OFS_TYPE_LO)) begin
				ftw_n[7:0] = b;
			end else if (ftw_q == eiph_pkg::ETH_TYPE_ARP &&
					(pos_q == POS_W'(eiph_pkg::OFS_ARP_OP_HI) ||
					 pos_q == POS_W'(eiph_pkg::OFS_ARP_OP_LO))) begin
				if (pos_q == POS_W'(eiph_pkg::OFS_ARP_OP_HI)) begin
					arp_op_n[15:8] = b;
				end else begin
					arp_op_n[7:0] = b;
				end
			end else if (ftw_q == eiph_pkg::ETH_TYPE_IPV4 &&
					pos_q >= POS_W'(eiph_pkg::OFS_IP)) begin
				if (ip_idx == '0) begin
					hl_n = {b[3:0], 2'b00};
				end
				if (ip_idx == POS_W'(eiph_pkg::IP_OFS_TOTLEN_HI)) begin
					tl_n[15:8] = b;
				end
				if (ip_idx == POS_W'(eiph_pkg::IP_OFS_TOTLEN_LO)) begin
					tl_n[7:0] = b;
				end
				if (ip_idx == POS_W'(eiph_pkg::IP_OFS_TTL)) begin
					ttl_n = b;
				end
				if (ip_idx == POS_W'(eiph_pkg::IP_OFS_PROTO)) begin
					proto_n = b;
				end
				if (ip_idx >= POS_W'(eiph_pkg::IP_OFS_ADDR) &&
						ip_idx < POS_W'(eiph_pkg::IP_OFS_ADDR_END)) begin
					asum_n = eiph_pkg::oc_add(asum_q, bword);
				end
				if (ip_idx < POS_W'(hl_n)) begin
					hsum_n = eiph_pkg::oc_add(hsum_q, bword);
				end else begin
					l4_idx  = ip_idx - POS_W'(hl_n);
					seg_len = tl_n - {10'd0, hl_n};
					if (l4_idx < POS_W'(eiph_pkg::L4_OFS_PORTS_END)) begin
						case (l4_idx[1:0])
							2'd0:    ports_n[31:24] = b;
							2'd1:    ports_n[23:16] = b;
							2'd2:    ports_n[15:8]  = b;
							default: ports_n[7:0]   = b;
						endcase
					end
					if (l4_idx == '0) begin
						icmp_n = b;
					end
					if (l4_idx == POS_W'(eiph_pkg::L4_OFS_TCP_FLAGS)) begin
						flags_n = b;
					end
					if (l4_idx >= POS_W'(eiph_pkg::L4_OFS_PORTS_END) &&
							17'(l4_idx) < 17'(seg_len)) begin
						ssum_n = eiph_pkg::oc_add(ssum_q, bword);
					end
				end
			end
		end
	end

	// frame state: cleared after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ftw_q    <= '0;
			hl_q     <= '0;
			tl_q     <= '0;
			proto_q  <= '0;
			hsum_q   <= '0;
			ssum_q   <= '0;
			asum_q   <= '0;
			ports_q  <= '0;
			ttl_q    <= '0;
			flags_q  <= '0;
			arp_op_q <= '0;
			icmp_q   <= '0;
		end else if (accept) begin
			if (frame.data.last_byte) begin
				pos_q    <= '0;
				ftw_q    <= '0;
				hl_q     <= '0;
				tl_q     <= '0;
				proto_q  <= '0;
				hsum_q   <= '0;
				ssum_q   <= '0;
				asum_q   <= '0;
				ports_q  <= '0;
				ttl_q    <= '0;
				flags_q  <= '0;
				arp_op_q <= '0;
				icmp_q   <= '0;
			end else begin
				pos_q    <= pos_n;
				ftw_q    <= ftw_n;
				hl_q     <= hl_n;
				tl_q     <= tl_n;
				proto_q  <= proto_n;
				hsum_q   <= hsum_n;
				ssum_q   <= ssum_n;
				asum_q   <= asum_n;
				ports_q  <= ports_n;
				ttl_q    <= ttl_n;
				flags_q  <= flags_n;
				arp_op_q <= arp_op_n;
				icmp_q   <= icmp_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (accept && frame.data.last_byte) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame.data.last_byte) begin
			snap_s1.frame_type <= ftw_n;
			snap_s1.hdr_len    <= hl_n;
			snap_s1.total_len  <= tl_n;
			snap_s1.protocol   <= proto_n;
			snap_s1.hdr_sum    <= hsum_n;
			snap_s1.seg_sum    <= ssum_n;
			snap_s1.addr_sum   <= asum_n;
			snap_s1.ports      <= ports_n;
			snap_s1.ttl        <= ttl_n;
			snap_s1.tcp_flags  <= flags_n;
			snap_s1.arp_op     <= arp_op_n;
			snap_s1.icmp_type  <= icmp_n;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/eiph_summary.sv =====
// Builds the frame summary from a snapshot; finishes the TCP checksum.
// Uses eiph_pkg and eiph_stream_if; two register stages to the output.
`default_nettype none

module eiph_summary (
	input  wire             clk,
	input  wire             arst_n,
	input  eiph_pkg::snap_t snap_s1,
	input  wire             snap_valid_s1,
	output logic            snap_ready,
	eiph_stream_if.source   summary
);
	eiph_pkg::result_t part;
	eiph_pkg::result_t part_s2;
	eiph_pkg::result_t out_d;
	logic              valid_s2;
	logic [15:0]       sum_a_s2, sum_b_s2, sum_c_s2;

	logic [15:0] seg_len;
	logic [15:0] src_w, dst_w;
	logic [15:0] tcp_sum;
	logic        out_adv;
	logic        adv_s2;

	assign out_adv    = !summary.valid || summary.ready;
	assign adv_s2     = !valid_s2 || out_adv;
	assign snap_ready = adv_s2;

	always_comb begin
		part    = '0;
		seg_len = snap_s1.total_len - {10'd0, snap_s1.hdr_len};

		if (snap_s1.frame_type == eiph_pkg::ETH_TYPE_ARP) begin
			part.frame_kind = eiph_pkg::FK_ARP;
			if (snap_s1.arp_op == eiph_pkg::ARP_OP_REQUEST) begin
				part.arp_kind = eiph_pkg::ARP_K_REQUEST;
			end else if (snap_s1.arp_op == eiph_pkg::ARP_OP_REPLY) begin
				part.arp_kind = eiph_pkg::ARP_K_REPLY;
			end else begin
				part.arp_kind = eiph_pkg::ARP_K_OTHER;
			end
		end else if (snap_s1.frame_type == eiph_pkg::ETH_TYPE_IPV4) begin
			part.frame_kind     = eiph_pkg::FK_IPV4;
			part.ip_header_len  = snap_s1.hdr_len;
			part.ip_checksum_ok = (snap_s1.hdr_sum == eiph_pkg::OC_ZERO_NEG);
			part.time_to_live   = snap_s1.ttl;
			unique case (snap_s1.protocol)
				eiph_pkg::IP_PROTO_TCP: begin
					part.l4_kind       = eiph_pkg::L4_TCP;
					part.source_port   = snap_s1.ports[31:16];
					part.dest_port     = snap_s1.ports[15:0];
					part.tcp_flag_bits = snap_s1.tcp_flags;
				end
				eiph_pkg::IP_PROTO_UDP: begin
					part.l4_kind     = eiph_pkg::L4_UDP;
					part.source_port = snap_s1.ports[31:16];
					part.dest_port   = snap_s1.ports[15:0];
				end
				eiph_pkg::IP_PROTO_ICMP: begin
					part.l4_kind   = eiph_pkg::L4_ICMP;
					part.icmp_kind = snap_s1.icmp_type;
				end
				default: begin
					part.l4_kind = eiph_pkg::L4_UNKNOWN;
				end
			endcase
		end else begin
			part.frame_kind = eiph_pkg::FK_OTHER;
		end

		// port bytes count only where they lie inside the segment
		if (seg_len == 16'd0) begin
			src_w = '0;
		end else if (seg_len == 16'd1) begin
			src_w = {snap_s1.ports[31:24], 8'h00};
		end else begin
			src_w = snap_s1.ports[31:16];
		end
		if (seg_len <= 16'd2) begin
			dst_w = '0;
		end else if (seg_len == 16'd3) begin
			dst_w = {snap_s1.ports[15:8], 8'h00};
		end else begin
			dst_w = snap_s1.ports[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= snap_valid_s1;
		end
	end

	// partial pseudo-header sums; final fold in the output stage
	always_ff @(posedge clk) begin
		if (adv_s2 && snap_valid_s1) begin
			part_s2  <= part;
			sum_a_s2 <= eiph_pkg::oc_add(snap_s1.seg_sum, src_w);
			sum_b_s2 <= eiph_pkg::oc_add(dst_w, snap_s1.addr_sum);
			sum_c_s2 <= eiph_pkg::oc_add({8'h00, snap_s1.protocol}, seg_len);
		end
	end

	assign tcp_sum = eiph_pkg::oc_add(eiph_pkg::oc_add(sum_a_s2, sum_b_s2), sum_c_s2);

	// output word: stage-2 fields plus the finished TCP check
	always_comb begin
		out_d                 = part_s2;
		out_d.tcp_checksum_ok = (part_s2.l4_kind == eiph_pkg::L4_TCP) &&
			(tcp_sum == eiph_pkg::OC_ZERO_NEG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary.valid <= 1'b0;
		end else if (out_adv) begin
			summary.valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			summary.data <= out_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ethernet_ip_header_parser.sv =====
// Ethernet/IPv4 header parser: one frame byte per beat, one summary per frame.
// Throughput: one byte per cycle; input stalls only while a snapshot waits on a stalled output.
// Path to the summary: snapshot on the edge that takes the last byte, then the
//   partial checksum stage, then the output register.
// Reset (arst_n low, async): frame state cleared, all pipeline valids dropped.
// Depends on eiph_pkg, eiph_stream_if, eiph_frame_track, eiph_summary.
`default_nettype none

`include "ethernet_ip_header_parser_defines.svh"

module ethernet_ip_header_parser #(
	// bytes past this position are ignored; last_byte still ends the frame
	parameter int unsigned MAX_FRAME_BYTES = eiph_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	eiph_stream_if.sink   frame,
	eiph_stream_if.source summary
);
	// Snapshot of the frame state, taken on the beat that carries last_byte.
	// The tracker clears itself on that same beat, so the next frame's first
	// byte can be taken in the following cycle unless snap_ready is low.
	eiph_pkg::snap_t snap_s1;
	logic            snap_valid_s1;
	logic            snap_ready;

	// terms for the checks at the end
	logic last_taken;
	logic out_ipv4, out_no_l4, out_tcp, out_tcp_ok, out_arp, out_no_arp_kind;

	// Byte tracker: ethertype, IPv4 header fields, running header,
	// address and segment sums, ports and small captured fields.
	eiph_frame_track #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.snap_s1      (snap_s1),
		.snap_valid_s1(snap_valid_s1),
		.snap_ready   (snap_ready)
	);

	// Summary builder: classifies the frame, masks fields that do not apply
	// and folds the TCP pseudo-header into the segment sum over two stages.
	// The output register holds a result under backpressure while bytes of
	// the next frame keep flowing into the tracker.
	eiph_summary u_summary (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_s1      (snap_s1),
		.snap_valid_s1(snap_valid_s1),
		.snap_ready   (snap_ready),
		.summary      (summary)
	);

	assign last_taken      = frame.valid && frame.ready && frame.data.last_byte;
	assign out_ipv4        = summary.data.frame_kind == eiph_pkg::FK_IPV4;
	assign out_no_l4       = summary.data.l4_kind == eiph_pkg::L4_NONE;
	assign out_tcp         = summary.data.l4_kind == eiph_pkg::L4_TCP;
	assign out_tcp_ok      = summary.data.tcp_checksum_ok;
	assign out_arp         = summary.data.frame_kind == eiph_pkg::FK_ARP;
	assign out_no_arp_kind = summary.data.arp_kind == eiph_pkg::ARP_K_OTHER;

	// A taken last byte always produces a snapshot in the next cycle.
	`EIPH_ASSERT_NEXT(a_last_snaps, last_taken, snap_valid_s1, "last byte gave no snapshot")
	// Layer-4 kind is only reported for IPv4 frames.
	`EIPH_ASSERT_IMPL(a_l4_ipv4_only, summary.valid, out_ipv4 || out_no_l4, "l4 kind on non-IPv4")
	// TCP checksum flag only for TCP.
	`EIPH_ASSERT_IMPL(a_tcp_ok_tcp_only, summary.valid && out_tcp_ok, out_tcp, "tcp ok on non-TCP")
	// ARP kind only for ARP frames.
	`EIPH_ASSERT_IMPL(a_arp_kind_arp_only, summary.valid && !out_arp, out_no_arp_kind, "arp kind on non-ARP")

endmodule

`default_nettype wire

// ===== verif/ethernet_ip_header_parser_test.sv =====
// Testbench for ethernet_ip_header_parser: frames go in one byte per beat and every
// frame summary is checked against a byte-level model of the parser kept in the bench.
// Depends on eiph_pkg, eiph_stream_if and the parser RTL.
`timescale 1ns / 1ps

module ethernet_ip_header_parser_test;
	import eiph_pkg::*;

	localparam int unsigned FRAME_LIMIT = MAX_FRAME_BYTES_DEF;

	logic clk;
	logic arst_n;

	eiph_stream_if #(.data_t(in_beat_t)) frame_ch ();
	eiph_stream_if #(.data_t(result_t)) summary_ch ();

	ethernet_ip_header_parser #(.MAX_FRAME_BYTES(FRAME_LIMIT)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.summary (summary_ch)
	);

	// frame under construction, sent byte by byte
	logic [7:0] frame_buf[$];
	// summaries the model expects, oldest first
	result_t expected_summaries[$];

	int unsigned error_count = 0;
	bit idle_on = 1'b1;   // sender inserts gaps between beats
	bit stall_on = 1'b1;  // receiver drops ready at random

	// model of the per-frame parse state
	logic [11:0] trk_pos;
	logic [15:0] trk_etype;
	logic [5:0]  trk_hlen;
	logic [15:0] trk_tlen;
	logic [7:0]  trk_proto;
	logic [15:0] trk_hsum;
	logic [15:0] trk_ssum;
	logic [15:0] trk_asum;
	logic [31:0] trk_ports;
	logic [7:0]  trk_ttl;
	logic [7:0]  trk_flags;
	logic [15:0] trk_arp_op;
	logic [7:0]  trk_icmp;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#10ms;
		$display("DONE: errors detected");
		$finish;
	end

	//------------------------------------------------------------------
	// ones'-complement helpers
	//------------------------------------------------------------------

	// 16-bit add with the carry wrapped back in
	function automatic logic [15:0] fold(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	// even offsets are the high byte of a word, odd ones the low byte
	function automatic logic [15:0] place(input logic [7:0] b, input logic odd);
		return odd ? {8'h00, b} : {b, 8'h00};
	endfunction

	// sum of count bytes of frame_buf from first; an odd tail is zero padded
	function automatic logic [15:0] sum_span(input int unsigned first, input int unsigned count);
		logic [15:0] acc;
		acc = '0;
		for (int unsigned k = 0; k < count; k++)
			acc = fold(acc, place(frame_buf[first + k], k[0]));
		return acc;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	//------------------------------------------------------------------
	// parser model
	//------------------------------------------------------------------

	task automatic clear_tracker();
		trk_pos = '0;
		trk_etype = '0;
		trk_hlen = '0;
		trk_tlen = '0;
		trk_proto = '0;
		trk_hsum = '0;
		trk_ssum = '0;
		trk_asum = '0;
		trk_ports = '0;
		trk_ttl = '0;
		trk_flags = '0;
		trk_arp_op = '0;
		trk_icmp = '0;
	endtask

	// one accepted byte; on the last byte the frame summary is queued
	task automatic track_byte(input logic [7:0] b, input logic last);
		logic [11:0] i;
		logic [11:0] j;
		logic [15:0] slen;
		logic [15:0] s;
		logic [7:0]  pb;
		result_t     r;
		if (trk_pos < FRAME_LIMIT) begin
			if (trk_pos == OFS_TYPE_HI)
				trk_etype[15:8] = b;
			else if (trk_pos == OFS_TYPE_LO)
				trk_etype[7:0] = b;
			else if (trk_etype == ETH_TYPE_ARP && trk_pos == OFS_ARP_OP_HI)
				trk_arp_op[15:8] = b;
			else if (trk_etype == ETH_TYPE_ARP && trk_pos == OFS_ARP_OP_LO)
				trk_arp_op[7:0] = b;
			else if (trk_etype == ETH_TYPE_IPV4 && trk_pos >= OFS_IP) begin
				i = trk_pos - 12'(OFS_IP);
				// header length takes effect on the very byte that carries it
				if (i == 0)
					trk_hlen = {b[3:0], 2'b00};
				if (i == IP_OFS_TOTLEN_HI)
					trk_tlen[15:8] = b;
				if (i == IP_OFS_TOTLEN_LO)
					trk_tlen[7:0] = b;
				if (i == IP_OFS_TTL)
					trk_ttl = b;
				if (i == IP_OFS_PROTO)
					trk_proto = b;
				if (i >= IP_OFS_ADDR && i < IP_OFS_ADDR_END)
					trk_asum = fold(trk_asum, place(b, i[0]));
				if (i < trk_hlen) begin
					trk_hsum = fold(trk_hsum, place(b, i[0]));
				end else begin
					// layer-4 bytes; with a short IHL these overlap the IP header
					j = i - 12'(trk_hlen);
					slen = trk_tlen - 16'(trk_hlen);
					if (j < L4_OFS_PORTS_END) begin
						case (j[1:0])
							2'd0: trk_ports[31:24] = b;
							2'd1: trk_ports[23:16] = b;
							2'd2: trk_ports[15:8] = b;
							default: trk_ports[7:0] = b;
						endcase
					end
					if (j == 0)
						trk_icmp = b;
					if (j == L4_OFS_TCP_FLAGS)
						trk_flags = b;
					// ethernet padding past the segment length is not summed
					if (j >= L4_OFS_PORTS_END && j < slen)
						trk_ssum = fold(trk_ssum, place(b, j[0]));
				end
			end
			trk_pos = trk_pos + 1'b1;
		end

		if (last) begin
			r = '0;
			if (trk_etype == ETH_TYPE_ARP) begin
				r.frame_kind = FK_ARP;
				if (trk_arp_op == ARP_OP_REQUEST)
					r.arp_kind = ARP_K_REQUEST;
				else if (trk_arp_op == ARP_OP_REPLY)
					r.arp_kind = ARP_K_REPLY;
				else
					r.arp_kind = ARP_K_OTHER;
			end else if (trk_etype == ETH_TYPE_IPV4) begin
				r.frame_kind = FK_IPV4;
				r.ip_header_len = trk_hlen;
				r.ip_checksum_ok = (trk_hsum == 16'hffff);
				r.time_to_live = trk_ttl;
				slen = trk_tlen - 16'(trk_hlen);
				case (trk_proto)
					IP_PROTO_TCP: begin
						r.l4_kind = L4_TCP;
						r.source_port = trk_ports[31:16];
						r.dest_port = trk_ports[15:0];
						r.tcp_flag_bits = trk_flags;
						// ports join the sum only where the segment covers them
						s = trk_ssum;
						for (int k = 0; k < 4; k++) begin
							pb = 8'(trk_ports >> (24 - 8 * k));
							if (k < slen)
								s = fold(s, place(pb, k[0]));
						end
						s = fold(s, trk_asum);
						s = fold(s, {8'h00, trk_proto});
						s = fold(s, slen);
						r.tcp_checksum_ok = (s == 16'hffff);
					end
					IP_PROTO_UDP: begin
						r.l4_kind = L4_UDP;
						r.source_port = trk_ports[31:16];
						r.dest_port = trk_ports[15:0];
					end
					IP_PROTO_ICMP: begin
						r.l4_kind = L4_ICMP;
						r.icmp_kind = trk_icmp;
					end
					default: r.l4_kind = L4_UNKNOWN;
				endcase
			end
			expected_summaries.push_back(r);
			clear_tracker();
		end
	endtask

	//------------------------------------------------------------------
	// checking
	//------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] MISMATCH %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	task automatic check_summary(input result_t got);
		result_t want;
		if (expected_summaries.size() == 0) begin
			report_mismatch("summary beat with no frame outstanding");
		end else begin
			want = expected_summaries.pop_front();
			check_field("frame_kind", 16'(got.frame_kind), 16'(want.frame_kind));
			check_field("l4_kind", 16'(got.l4_kind), 16'(want.l4_kind));
			check_field("ip_header_len", 16'(got.ip_header_len), 16'(want.ip_header_len));
			check_field("ip_checksum_ok", 16'(got.ip_checksum_ok), 16'(want.ip_checksum_ok));
			check_field("tcp_checksum_ok", 16'(got.tcp_checksum_ok),
				16'(want.tcp_checksum_ok));
			check_field("source_port", got.source_port, want.source_port);
			check_field("dest_port", got.dest_port, want.dest_port);
			check_field("tcp_flag_bits", 16'(got.tcp_flag_bits), 16'(want.tcp_flag_bits));
			check_field("arp_kind", 16'(got.arp_kind), 16'(want.arp_kind));
			check_field("icmp_kind", 16'(got.icmp_kind), 16'(want.icmp_kind));
			check_field("time_to_live", 16'(got.time_to_live), 16'(want.time_to_live));
		end
	endtask

	// Inputs only move at the rising edge, so the values seen at the falling edge
	// are the ones the next rising edge takes: a beat is counted here, race free.
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1 && summary_ch.valid === 1'b1 && summary_ch.ready === 1'b1)
				check_summary(summary_ch.data);
		end
	end

	//------------------------------------------------------------------
	// receiver: random back-pressure on the summary channel
	//------------------------------------------------------------------

	initial begin
		summary_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			summary_ch.ready <= 1'b1;
			if (!stall_on) begin
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
				summary_ch.ready <= 1'b0;
				if ($urandom_range(0, 9) < 8)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else
					repeat ($urandom_range(6, 30)) @(posedge clk);
			end
		end
	end

	//------------------------------------------------------------------
	// sender
	//------------------------------------------------------------------

	// mostly back to back, some short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// called at a rising edge; returns at the rising edge that took the beat
	task automatic send_beat(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data <= {b, last};
		do
			@(negedge clk);
		while (frame_ch.ready !== 1'b1);
		@(posedge clk);
		track_byte(b, last);
	endtask

	task automatic send_frame();
		foreach (frame_buf[k])
			send_beat(frame_buf[k], k == frame_buf.size() - 1);
	endtask

	// hold the sender until every queued summary has come back
	task automatic wait_for_summaries();
		frame_ch.valid <= 1'b0;
		wait (expected_summaries.size() == 0);
		@(posedge clk);
	endtask

	//------------------------------------------------------------------
	// frame builders
	//------------------------------------------------------------------

	task automatic start_frame(input logic [15:0] etype);
		frame_buf.delete();
		repeat (12) frame_buf.push_back(rand_byte());
		frame_buf.push_back(etype[15:8]);
		frame_buf.push_back(etype[7:0]);
	endtask

	// IPv4 frame (ihl >= 5) with correct header checksum; TCP checksum set if seg_len > 17
	task automatic build_ipv4(input logic [7:0] proto, input int unsigned ihl,
			input int unsigned seg_len, input int unsigned pad, input logic [7:0] ttl);
		int unsigned hl;
		int unsigned seg0;
		logic [15:0] total;
		logic [15:0] csum;
		start_frame(ETH_TYPE_IPV4);
		hl = ihl * 4;
		total = 16'(hl + seg_len);
		frame_buf.push_back({4'h4, 4'(ihl)});
		frame_buf.push_back(rand_byte());
		frame_buf.push_back(total[15:8]);
		frame_buf.push_back(total[7:0]);
		repeat (4) frame_buf.push_back(rand_byte());
		frame_buf.push_back(ttl);
		frame_buf.push_back(proto);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h00);
		// addresses, then options
		repeat (hl - 12) frame_buf.push_back(rand_byte());
		seg0 = frame_buf.size();
		repeat (seg_len) frame_buf.push_back(rand_byte());
		if (proto == IP_PROTO_TCP && seg_len > 12)
			frame_buf[seg0 + 12] = 8'h50;
		if (proto == IP_PROTO_ICMP && seg_len > 0) begin
			case ($urandom_range(0, 2))
				0: frame_buf[seg0] = 8'd0;
				1: frame_buf[seg0] = 8'd8;
				default: frame_buf[seg0] = rand_byte();
			endcase
		end
		csum = ~sum_span(OFS_IP, hl);
		frame_buf[OFS_IP + 10] = csum[15:8];
		frame_buf[OFS_IP + 11] = csum[7:0];
		if (proto == IP_PROTO_TCP && seg_len > 17) begin
			frame_buf[seg0 + 16] = 8'h00;
			frame_buf[seg0 + 17] = 8'h00;
			csum = fold(sum_span(OFS_IP + IP_OFS_ADDR, 8), {8'h00, proto});
			csum = fold(csum, 16'(seg_len));
			csum = ~fold(csum, sum_span(seg0, seg_len));
			frame_buf[seg0 + 16] = csum[15:8];
			frame_buf[seg0 + 17] = csum[7:0];
		end
		// ethernet padding goes in after the checksums
		repeat (pad) frame_buf.push_back(rand_byte());
	endtask

	task automatic build_arp(input logic [15:0] op, input int unsigned pad);
		start_frame(ETH_TYPE_ARP);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h01);
		frame_buf.push_back(8'h08);
		frame_buf.push_back(8'h00);
		frame_buf.push_back(8'h06);
		frame_buf.push_back(8'h04);
		frame_buf.push_back(op[15:8]);
		frame_buf.push_back(op[7:0]);
		repeat (20 + pad) frame_buf.push_back(rand_byte());
	endtask

	task automatic build_random_frame();
		int unsigned r;
		int unsigned n;
		logic [7:0] proto;
		int unsigned seg_len;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0: begin
					proto = IP_PROTO_TCP;
					seg_len = $urandom_range(14, 40);
				end
				1: begin
					proto = IP_PROTO_UDP;
					seg_len = $urandom_range(8, 30);
				end
				2: begin
					proto = IP_PROTO_ICMP;
					seg_len = $urandom_range(4, 20);
				end
				default: begin
					proto = rand_byte();
					seg_len = $urandom_range(0, 20);
				end
			endcase
			build_ipv4(proto, ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5,
				seg_len, ($urandom_range(0, 9) < 3) ? $urandom_range(1, 8) : 0, rand_byte());
			// most frames stay clean; the rest get damaged in one way
			case ($urandom_range(0, 9))
				0: begin
					n = $urandom_range(0, frame_buf.size() - 1);
					frame_buf[n] = frame_buf[n] ^ (8'h01 << $urandom_range(0, 7));
				end
				1: begin
					n = $urandom_range(1, frame_buf.size() - 1);
					while (frame_buf.size() > n)
						void'(frame_buf.pop_back());
				end
				2: frame_buf[OFS_IP] = {4'h4, 4'($urandom)};
				default: ;
			endcase
		end else if (r < 75) begin
			case ($urandom_range(0, 2))
				0: build_arp(ARP_OP_REQUEST, $urandom_range(0, 18));
				1: build_arp(ARP_OP_REPLY, $urandom_range(0, 18));
				default: build_arp(16'($urandom), $urandom_range(0, 18));
			endcase
		end else if (r < 85) begin
			start_frame(16'($urandom));
			repeat ($urandom_range(0, 40)) frame_buf.push_back(rand_byte());
		end else begin
			// raw noise, sometimes carrying a known ethertype
			frame_buf.delete();
			repeat ($urandom_range(1, 64)) frame_buf.push_back(rand_byte());
			if (frame_buf.size() > 14 && $urandom_range(0, 1) == 1) begin
				frame_buf[OFS_TYPE_HI] = 8'h08;
				frame_buf[OFS_TYPE_LO] = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'h06;
			end
		end
	endtask

	//------------------------------------------------------------------
	// tests
	//------------------------------------------------------------------

	// frames that end before, inside or right after the ethertype, plus all-ones and all-zeros frames
	task automatic test_frame_boundaries();
		frame_buf.delete();
		frame_buf.push_back(8'hff);
		send_frame();
		// 13 bytes: high ethertype byte alone already reads as IPv4
		frame_buf.delete();
		repeat (12) frame_buf.push_back(rand_byte());
		frame_buf.push_back(8'h08);
		send_frame();
		start_frame(ETH_TYPE_IPV4);
		send_frame();
		frame_buf.delete();
		repeat (40) frame_buf.push_back(8'hff);
		send_frame();
		frame_buf.delete();
		repeat (30) frame_buf.push_back(8'h00);
		send_frame();
		wait_for_summaries();
	endtask

	task automatic test_arp_opcodes();
		build_arp(ARP_OP_REQUEST, 0);
		send_frame();
		build_arp(ARP_OP_REPLY, 18);
		send_frame();
		build_arp(16'hffff, 4);
		send_frame();
		// cut after the high opcode byte
		build_arp(ARP_OP_REQUEST, 0);
		while (frame_buf.size() > OFS_ARP_OP_LO)
			void'(frame_buf.pop_back());
		send_frame();
		wait_for_summaries();
	endtask

	task automatic test_ip_protocols();
		build_ipv4(IP_PROTO_TCP, 5, 20, 6, 8'hff);
		send_frame();
		// odd segment length, zero padded in the sum, followed by padding
		build_ipv4(IP_PROTO_TCP, 6, 21, 5, 8'h00);
		send_frame();
		build_ipv4(IP_PROTO_TCP, 15, 24, 0, 8'h40);
		send_frame();
		build_ipv4(IP_PROTO_UDP, 5, 8, 10, 8'h80);
		send_frame();
		build_ipv4(IP_PROTO_ICMP, 5, 8, 0, 8'h01);
		frame_buf[OFS_IP + 20] = 8'd0;
		send_frame();
		build_ipv4(IP_PROTO_ICMP, 5, 8, 0, 8'h7f);
		frame_buf[OFS_IP + 20] = 8'd8;
		send_frame();
		build_ipv4(8'hff, 5, 10, 0, 8'h33);
		send_frame();
		wait_for_summaries();
	endtask

	task automatic test_checksum_errors();
		build_ipv4(IP_PROTO_TCP, 5, 26, 0, 8'h20);
		frame_buf[OFS_IP + 30] = frame_buf[OFS_IP + 30] ^ 8'h01;
		send_frame();
		build_ipv4(IP_PROTO_TCP, 5, 20, 0, 8'h20);
		frame_buf[OFS_IP + IP_OFS_TTL] = frame_buf[OFS_IP + IP_OFS_TTL] ^ 8'h80;
		send_frame();
		// short frame: missing segment bytes count as zero
		build_ipv4(IP_PROTO_TCP, 5, 30, 0, 8'h20);
		repeat (9) void'(frame_buf.pop_back());
		send_frame();
		wait_for_summaries();
	endtask

	task automatic test_odd_headers();
		// IHL 0: empty header sum, layer-4 starts on the version byte
		build_ipv4(IP_PROTO_TCP, 5, 20, 0, 8'h11);
		frame_buf[OFS_IP] = 8'h40;
		send_frame();
		build_ipv4(IP_PROTO_UDP, 5, 12, 0, 8'h22);
		frame_buf[OFS_IP] = 8'h43;
		send_frame();
		// total length below the header length: segment length wraps
		build_ipv4(IP_PROTO_TCP, 5, 20, 0, 8'h33);
		frame_buf[OFS_IP + IP_OFS_TOTLEN_HI] = 8'h00;
		frame_buf[OFS_IP + IP_OFS_TOTLEN_LO] = 8'h04;
		send_frame();
		wait_for_summaries();
	endtask

	task automatic test_random_traffic();
		int unsigned byte_count;
		int unsigned frame_count;
		byte_count = 0;
		frame_count = 0;
		while (byte_count < 400) begin
			// a stretch with no gaps or stalls in the middle of the run
			idle_on = !(frame_count >= 3 && frame_count < 6);
			stall_on = idle_on;
			build_random_frame();
			byte_count += frame_buf.size();
			send_frame();
			frame_count++;
			if ($urandom_range(0, 9) == 0)
				wait_for_summaries();
		end
		idle_on = 1'b1;
		stall_on = 1'b1;
	endtask

	//------------------------------------------------------------------
	// main sequence
	//------------------------------------------------------------------

	initial begin
		clear_tracker();
		arst_n <= 1'b0;
		frame_ch.valid <= 1'b0;
		frame_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_boundaries();
		test_arp_opcodes();
		test_ip_protocols();
		test_checksum_errors();
		test_odd_headers();
		test_random_traffic();

		// drain, then stay idle to catch any stray summary beat
		frame_ch.valid <= 1'b0;
		wait (expected_summaries.size() == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/eiph_pkg.sv
hw/rtl/eiph_stream_if.sv
hw/rtl/eiph_frame_track.sv
hw/rtl/eiph_summary.sv
hw/rtl/ethernet_ip_header_parser.sv
verif/ethernet_ip_header_parser_test.sv
